// ----- design/assert_macros.svh -----
// Assertion macros shared by the Lennard-Jones force unit.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define LJ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lj check failed");

// Next-cycle implication, checked on every rising edge out of reset.
`define LJ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lj check failed");

`endif

// ----- design/lj_pkg.sv -----
// Shared widths, constants and types of the Lennard-Jones force unit.
// Used by lj_mulq, lj_div and the top level; depends on nothing.
package lj_pkg;

  localparam int unsigned POS_W    = 32;  // Q16.16 coordinate
  localparam int unsigned AD_W     = 32;  // magnitude of a coordinate difference
  localparam int unsigned R2_W     = 50;  // r squared, Q34.16
  localparam int unsigned Q_W      = 64;  // quotients and fixed-point products
  localparam int unsigned KIND_W   = 8;
  localparam int unsigned CFG_W    = 32;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned EPS_SCALE = 24;
  localparam int unsigned DIV_STAGES = Q_W;

  localparam logic [CFG_IDX_W-1:0] REG_WELL_DEPTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_RADIUS = 1'd1;
  localparam logic [CFG_W-1:0]     CFG_RESET_ONE   = 32'h0001_0000;

  localparam logic [31:0] FORCE_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] FORCE_MIN = 32'h8000_0000;

  // Per-pair data that rides alongside the divider and multiplier chain.
  typedef struct packed {
    logic [2:0][AD_W-1:0] ad;
    logic [2:0]           neg;
    logic                 used;
    logic                 zero;
  } side_t;

endpackage

// ----- design/lj_mulq.sv -----
// Two-stage Q48.16 multiplier with an unbounded ("huge") marker on both sides.
// Depends on lj_pkg for the operand width.
module lj_mulq (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [lj_pkg::Q_W-1:0]   x_i,
  input  logic                     xh_i,
  input  logic [lj_pkg::Q_W-1:0]   y_i,
  input  logic                     yh_i,
  output logic [lj_pkg::Q_W-1:0]   z_o,
  output logic                     zh_o
);

  logic [63:0]  p00_q, p01_q, p10_q, p11_q;
  logic         zero_q, hg_q;
  logic [127:0] full;
  logic [63:0]  z_q;
  logic         zh_q;

  // First stage: four 32x32 partial products.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p00_q  <= 64'(x_i[31:0])  * 64'(y_i[31:0]);
      p01_q  <= 64'(x_i[31:0])  * 64'(y_i[63:32]);
      p10_q  <= 64'(x_i[63:32]) * 64'(y_i[31:0]);
      p11_q  <= 64'(x_i[63:32]) * 64'(y_i[63:32]);
      zero_q <= (!xh_i && x_i == '0) || (!yh_i && y_i == '0);
      hg_q   <= xh_i || yh_i;
    end
  end

  assign full = {64'd0, p00_q} + {32'd0, p01_q, 32'd0} + {32'd0, p10_q, 32'd0} +
                {p11_q, 64'd0};

  // Second stage: sum, rescale and flag anything at or above 2^80 raw.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zh_q <= !zero_q && (hg_q || full[127:80] != '0);
      z_q  <= (zero_q || hg_q) ? '0 : full[79:16];
    end
  end

  assign z_o  = z_q;
  assign zh_o = zh_q;

endmodule

// ----- design/lj_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, two dividends
// sharing one divisor. Depends on lj_pkg for widths and the side_t type.
module lj_div (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic [lj_pkg::Q_W-1:0]  num_a_i,
  input  logic [lj_pkg::Q_W-1:0]  num_b_i,
  input  logic [lj_pkg::R2_W-1:0] den_i,
  input  lj_pkg::side_t           side_i,
  output logic                    valid_o,
  output logic [lj_pkg::Q_W-1:0]  quo_a_o,
  output logic [lj_pkg::Q_W-1:0]  quo_b_o,
  output lj_pkg::side_t           side_o
);

  localparam int unsigned NS = lj_pkg::DIV_STAGES;
  localparam int unsigned RW = lj_pkg::R2_W;
  localparam int unsigned QW = lj_pkg::Q_W;

  logic [RW-1:0]  rem_a_q [NS];
  logic [RW-1:0]  rem_b_q [NS];
  logic [RW-1:0]  den_q   [NS];
  logic [QW-1:0]  nq_a_q  [NS];
  logic [QW-1:0]  nq_b_q  [NS];
  lj_pkg::side_t  side_q  [NS];
  logic [NS-1:0]  valid_q;

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic [RW-1:0] ra, rb, dn;
    logic [QW-1:0] na, nb;
    lj_pkg::side_t sd;
    logic          vl;
    logic [RW:0]   ta, tb;
    logic          ga, gb;

    if (s == 0) begin : g_first
      assign ra = '0;
      assign rb = '0;
      assign dn = den_i;
      assign na = num_a_i;
      assign nb = num_b_i;
      assign sd = side_i;
      assign vl = valid_i;
    end else begin : g_next
      assign ra = rem_a_q[s-1];
      assign rb = rem_b_q[s-1];
      assign dn = den_q[s-1];
      assign na = nq_a_q[s-1];
      assign nb = nq_b_q[s-1];
      assign sd = side_q[s-1];
      assign vl = valid_q[s-1];
    end

    // Shift the next dividend bit into the partial remainder.
    assign ta = {ra, na[QW-1]};
    assign tb = {rb, nb[QW-1]};
    assign ga = ta >= {1'b0, dn};
    assign gb = tb >= {1'b0, dn};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_a_q[s] <= ga ? RW'(ta - {1'b0, dn}) : ta[RW-1:0];
        rem_b_q[s] <= gb ? RW'(tb - {1'b0, dn}) : tb[RW-1:0];
        nq_a_q[s]  <= {na[QW-2:0], ga};
        nq_b_q[s]  <= {nb[QW-2:0], gb};
        den_q[s]   <= dn;
        side_q[s]  <= sd;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (en_i) begin
        valid_q[s] <= vl;
      end
    end
  end

  assign valid_o = valid_q[NS-1];
  assign quo_a_o = nq_a_q[NS-1];
  assign quo_b_o = nq_b_q[NS-1];
  assign side_o  = side_q[NS-1];

endmodule

// ----- design/lennard_jones_pair_force_unit.sv -----
// Lennard-Jones pair force unit: top level with input stages, divider,
// multiplier chain and output register. Depends on lj_pkg, lj_div, lj_mulq.
//
// Usage: a pair item enters on the s_axis channel (three coordinates of A,
// three of B, and both type codes in tuser). One result item leaves on the
// m_axis channel: the force on A in tdata and the pair_used, zero_distance
// and saturated flags in tuser. Every pair gives exactly one result.
// The unit takes one item per cycle while it is not stalled. An item passes
// through three input stages, a 64-stage divider that forms sigma^2/r^2 and
// 24*eps/r^2 at one quotient bit per stage, five two-stage multipliers in a
// chain, one stage that forms 2q^6-q^3 and one that clips. The user must write
// the well depth and zero radius registers through the cfg port only while no
// item is in flight; the unit does not enforce it. Reset sets both to 1.0 and
// empties the pipe. When the receiver holds m_axis_tready low with a result
// waiting, the whole pipeline freezes and s_axis_tready drops; nothing is lost or repeated.
module lennard_jones_pair_force_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [lj_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [lj_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z
  input  logic [191:0]                 s_axis_tdata,
  // kind_a, kind_b
  input  logic [15:0]                  s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // force_x, force_y, force_z
  output logic [95:0]                  m_axis_tdata,
  // pair_used, zero_distance, saturated
  output logic [2:0]                   m_axis_tuser
);

  `include "assert_macros.svh"

  localparam int unsigned QW = lj_pkg::Q_W;
  localparam int unsigned AW = lj_pkg::AD_W;
  localparam int unsigned PW = lj_pkg::POS_W;
  localparam int unsigned POST = 11;

  logic en;
  logic [lj_pkg::CFG_W-1:0] eps_q, sigma_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q   <= lj_pkg::CFG_RESET_ONE;
      sigma_q <= lj_pkg::CFG_RESET_ONE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lj_pkg::REG_WELL_DEPTH:  eps_q   <= cfg_wdata_i;
        lj_pkg::REG_ZERO_RADIUS: sigma_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic out_valid_q;
  assign en            = m_axis_tready || !out_valid_q;
  assign s_axis_tready = en;

  // Stage 1: coordinate differences as sign and magnitude.
  logic [2:0][AW-1:0] ad1_d;
  logic [2:0]         neg1_d;
  logic [2:0][AW-1:0] ad1_q;
  logic [2:0]         neg1_q;
  logic               used1_q, v1_q;

  always_comb begin
    logic signed [PW:0] d;
    for (int i = 0; i < 3; i++) begin
      d = {s_axis_tdata[i*PW + PW-1], s_axis_tdata[i*PW +: PW]} -
          {s_axis_tdata[(i+3)*PW + PW-1], s_axis_tdata[(i+3)*PW +: PW]};
      neg1_d[i] = d[PW];
      ad1_d[i]  = d[PW] ? AW'(~d + 33'sd1) : d[AW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ad1_q   <= ad1_d;
      neg1_q  <= neg1_d;
      used1_q <= s_axis_tuser[7:0] < s_axis_tuser[15:8];
    end
  end

  // Stage 2: squared magnitudes, rescaled to Q32.16.
  logic [2:0][47:0]   sq2_q;
  logic [2:0][AW-1:0] ad2_q;
  logic [2:0]         neg2_q;
  logic               used2_q, v2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq2_q[i] <= 48'((64'(ad1_q[i]) * 64'(ad1_q[i])) >> 16);
      end
      ad2_q   <= ad1_q;
      neg2_q  <= neg1_q;
      used2_q <= used1_q;
    end
  end

  // Stage 3: r squared, sigma squared and the scaled epsilon dividend.
  logic [lj_pkg::R2_W-1:0] r2_3_q;
  logic [QW-1:0]           s2_3_q, gnum3_q;
  lj_pkg::side_t           side3_q;
  logic                    v3_q;

  always_ff @(posedge clk_i) begin
    logic [lj_pkg::R2_W-1:0] r2;
    logic [36:0]             eps24;
    if (en) begin
      r2 = lj_pkg::R2_W'(sq2_q[0]) + lj_pkg::R2_W'(sq2_q[1]) + lj_pkg::R2_W'(sq2_q[2]);
      eps24 = 37'(eps_q) * 37'(lj_pkg::EPS_SCALE);
      r2_3_q       <= r2;
      s2_3_q       <= 64'(sigma_q) * 64'(sigma_q);
      gnum3_q      <= QW'({eps24, 16'd0});
      side3_q.ad   <= ad2_q;
      side3_q.neg  <= neg2_q;
      side3_q.used <= used2_q;
      side3_q.zero <= r2 == '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Divider: q = sigma^2 / r2 and g = 24*eps / r2.
  logic          dv;
  logic [QW-1:0] dq, dg;
  lj_pkg::side_t dside;

  lj_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v3_q),
    .num_a_i (s2_3_q),
    .num_b_i (gnum3_q),
    .den_i   (r2_3_q),
    .side_i  (side3_q),
    .valid_o (dv),
    .quo_a_o (dq),
    .quo_b_o (dg),
    .side_o  (dside)
  );

  // Delay lines beside the multiplier chain; each entry registers the one before it.
  logic [POST-1:0] pv_q;
  lj_pkg::side_t   ps_q [POST];
  logic [QW-1:0]   qd_q [2];
  logic [QW-1:0]   q3d_q [2];
  logic [QW-1:0]   gd_q [7];
  logic [3:0]      wn_q;

  logic [QW-1:0] qq, q3, q6, m, w_q;
  logic          qqh, q3h, q6h, mh, wh_q, wneg_q;
  logic [2:0][QW-1:0] p;
  logic [2:0]         ph;

  lj_mulq u_mul_qq (
    .clk_i (clk_i), .en_i (en),
    .x_i (dq), .xh_i (1'b0), .y_i (dq), .yh_i (1'b0),
    .z_o (qq), .zh_o (qqh)
  );

  lj_mulq u_mul_q3 (
    .clk_i (clk_i), .en_i (en),
    .x_i (qq), .xh_i (qqh), .y_i (qd_q[1]), .yh_i (1'b0),
    .z_o (q3), .zh_o (q3h)
  );

  lj_mulq u_mul_q6 (
    .clk_i (clk_i), .en_i (en),
    .x_i (q3), .xh_i (q3h), .y_i (q3), .yh_i (q3h),
    .z_o (q6), .zh_o (q6h)
  );

  lj_mulq u_mul_m (
    .clk_i (clk_i), .en_i (en),
    .x_i (gd_q[6]), .xh_i (1'b0), .y_i (w_q), .yh_i (wh_q),
    .z_o (m), .zh_o (mh)
  );

  for (genvar i = 0; i < 3; i++) begin : g_force
    lj_mulq u_mul_f (
      .clk_i (clk_i), .en_i (en),
      .x_i (m), .xh_i (mh), .y_i (QW'(ps_q[8].ad[i])), .yh_i (1'b0),
      .z_o (p[i]), .zh_o (ph[i])
    );
  end

  always_ff @(posedge clk_i) begin
    logic [QW-1:0] tv;
    logic          th;
    if (en) begin
      ps_q[0] <= dside;
      for (int k = 1; k < POST; k++) begin
        ps_q[k] <= ps_q[k-1];
      end
      qd_q[0]  <= dq;
      qd_q[1]  <= qd_q[0];
      q3d_q[0] <= q3;
      q3d_q[1] <= q3d_q[0];
      gd_q[0]  <= dg;
      for (int k = 1; k < 7; k++) begin
        gd_q[k] <= gd_q[k-1];
      end
      // w = 2*q6 - q3 as sign and magnitude; a doubled q6 past 64 bits
      // is unbounded and positive.
      th = q6h || q6[QW-1];
      tv = {q6[QW-2:0], 1'b0};
      if (th) begin
        w_q <= '0;
        wh_q <= 1'b1;
        wneg_q <= 1'b0;
      end else if (tv >= q3d_q[1]) begin
        w_q <= tv - q3d_q[1];
        wh_q <= 1'b0;
        wneg_q <= 1'b0;
      end else begin
        w_q <= q3d_q[1] - tv;
        wh_q <= 1'b0;
        wneg_q <= 1'b1;
      end
      wn_q <= {wn_q[2:0], wneg_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= '0;
    end else if (en) begin
      pv_q <= {pv_q[POST-2:0], dv};
    end
  end

  // Final stage: sign, clip and the special cases.
  logic [2:0][31:0] f_d;
  logic [2:0]       sat_d;
  logic [95:0]      out_data_q;
  logic [2:0]       out_user_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sat_d[i] = 1'b0;
      if (!ph[i] && p[i] == '0) begin
        f_d[i] = '0;
      end else if (wn_q[3] != ps_q[10].neg[i]) begin
        if (ph[i] || p[i] > QW'(lj_pkg::FORCE_MIN)) begin
          f_d[i]   = lj_pkg::FORCE_MIN;
          sat_d[i] = 1'b1;
        end else begin
          f_d[i] = 32'(~p[i] + 64'd1);
        end
      end else begin
        if (ph[i] || p[i] > QW'(lj_pkg::FORCE_MAX)) begin
          f_d[i]   = lj_pkg::FORCE_MAX;
          sat_d[i] = 1'b1;
        end else begin
          f_d[i] = p[i][31:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (!ps_q[10].used) begin
        out_data_q <= '0;
        out_user_q <= '0;
      end else if (ps_q[10].zero) begin
        out_data_q <= '0;
        out_user_q <= 3'b011;
      end else begin
        out_data_q <= {f_d[2], f_d[1], f_d[0]};
        out_user_q <= {|sat_d, 1'b0, 1'b1};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= pv_q[POST-1];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  `LJ_ASSERT_IMP(a_unused_is_zero, m_axis_tvalid && !m_axis_tuser[0],
                 m_axis_tdata == '0 && m_axis_tuser == '0)
  `LJ_ASSERT_IMP(a_zero_dist_clean, m_axis_tvalid && m_axis_tuser[1],
                 m_axis_tuser[0] && !m_axis_tuser[2] && m_axis_tdata == '0)
  `LJ_ASSERT_IMP(a_sat_has_clip, m_axis_tvalid && m_axis_tuser[2],
                 m_axis_tdata[31:0] == lj_pkg::FORCE_MAX ||
                 m_axis_tdata[31:0] == lj_pkg::FORCE_MIN ||
                 m_axis_tdata[63:32] == lj_pkg::FORCE_MAX ||
                 m_axis_tdata[63:32] == lj_pkg::FORCE_MIN ||
                 m_axis_tdata[95:64] == lj_pkg::FORCE_MAX ||
                 m_axis_tdata[95:64] == lj_pkg::FORCE_MIN)
  `LJ_ASSERT_NXT(a_stall_freezes, m_axis_tvalid && !m_axis_tready,
                 $stable(pv_q) && $stable(v3_q))

endmodule
